[rtl/position_velocity_kalman_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the position/velocity Kalman filter
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef POSITION_VELOCITY_KALMAN_DEFINES_SVH
`define POSITION_VELOCITY_KALMAN_DEFINES_SVH

// Clocked property, disabled while reset is asserted (active low).
`define PVK_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that holds during reset as well.
`define PVK_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pvk_pkg.sv]
// ----------------------------------------------------------------------------
// pvk_pkg
// Types, constants and sequencing helpers of the Kalman filter block.
// ----------------------------------------------------------------------------
package pvk_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned CFG_W  = 31;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_QPOS = 3'd0;
    localparam logic [2:0] REG_QVEL = 3'd1;
    localparam logic [2:0] REG_RMEAS = 3'd2;
    localparam logic [2:0] REG_PVAR = 3'd3;
    localparam logic [2:0] REG_VVAR = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_QPOS = 31'd655360;
    localparam logic [CFG_W-1:0] RST_QVEL = 31'd65536000;
    localparam logic [CFG_W-1:0] RST_RMEAS = 31'd6553600;
    localparam logic [CFG_W-1:0] RST_PVAR = 31'd65536000;
    localparam logic [CFG_W-1:0] RST_VVAR = 31'd655360000;

    // Time step constants
    localparam logic [63:0] DT_DEFAULT = 64'd65;
    localparam logic [31:0] Q16_ONE    = 32'h0001_0000;

    // Reciprocal of 15625 scaled by 2^56 (rounded up), split in 32-bit halves:
    // dt = (span * HI + ((span * LO) >> 32)) >> 14 = floor(span * 65536 / 1e6)
    localparam logic [63:0] DT_RECIP_LO = 64'd3186109820;
    localparam logic [63:0] DT_RECIP_HI = 64'd1073;

    typedef struct packed {
        logic [CFG_W-1:0] qpos;
        logic [CFG_W-1:0] qvel;
        logic [CFG_W-1:0] rmeas;
        logic [CFG_W-1:0] pvar;
        logic [CFG_W-1:0] vvar;
    } t_cfg;

    // Datapath operations, in sequence order for a measurement update
    typedef enum logic [4:0] {
        OP_RESET,
        OP_DT,
        OP_DTH,
        OP_VDT,
        OP_PVDT,
        OP_VPDT,
        OP_VVDT,
        OP_VVDT2,
        OP_SUMS,
        OP_K0,
        OP_K1,
        OP_POS,
        OP_VEL,
        OP_PP,
        OP_PV,
        OP_VP,
        OP_VV
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic s_zero;
    } t_dp_stat;

    function automatic t_op next_op(input t_op op);
        t_op r;
        unique case (op)
            OP_DT:    r = OP_DTH;
            OP_DTH:   r = OP_VDT;
            OP_VDT:   r = OP_PVDT;
            OP_PVDT:  r = OP_VPDT;
            OP_VPDT:  r = OP_VVDT;
            OP_VVDT:  r = OP_VVDT2;
            OP_VVDT2: r = OP_SUMS;
            OP_SUMS:  r = OP_K0;
            OP_K0:    r = OP_K1;
            OP_K1:    r = OP_POS;
            OP_POS:   r = OP_VEL;
            OP_VEL:   r = OP_PP;
            OP_PP:    r = OP_PV;
            OP_PV:    r = OP_VP;
            OP_VP:    r = OP_VV;
            default:  r = OP_RESET;
        endcase
        return r;
    endfunction

    function automatic logic op_is_div(input t_op op);
        return (op == OP_K0) || (op == OP_K1);
    endfunction

    function automatic logic op_is_inst(input t_op op);
        return (op == OP_RESET) || (op == OP_SUMS);
    endfunction

endpackage

[rtl/pvk_mul.sv]
// ----------------------------------------------------------------------------
// pvk_mul
// 64 x 64 multiply, low 64 bits kept, built from three 32 x 32 partial
// products on one shared multiplier, one per cycle.
// ----------------------------------------------------------------------------
module pvk_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic [63:0] r_a, r_b, r_prod, r_acc;
    logic [1:0]  r_step;
    logic        r_busy, r_done;
    logic [31:0] mul_x, mul_y;

    // Pick the operand halves for this step
    always_comb begin
        case (r_step)
            2'd0:    begin mul_x = r_a[31:0];  mul_y = r_b[31:0];  end
            2'd1:    begin mul_x = r_a[31:0];  mul_y = r_b[63:32]; end
            default: begin mul_x = r_a[63:32]; mul_y = r_b[31:0];  end
        endcase
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial products and accumulation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            if (r_step != 2'd3) begin
                r_prod <= {32'd0, mul_x} * {32'd0, mul_y};
            end
            case (r_step)
                2'd0:    ;
                2'd1:    r_acc <= r_prod;
                default: r_acc <= r_acc + {r_prod[31:0], 32'd0};
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[rtl/pvk_div.sv]
// ----------------------------------------------------------------------------
// pvk_div
// Restoring divider, 48-bit magnitude by 32-bit magnitude, one quotient bit
// per cycle, sign applied at the end (truncation toward zero).
// ----------------------------------------------------------------------------
module pvk_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    input  logic        i_neg,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [31:0] r_rem, r_den;
    logic [47:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_neg, r_busy, r_done;
    logic [32:0] trial;
    logic        fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[47]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_quo <= {r_quo[46:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (64'd0 - {16'd0, r_quo}) : {16'd0, r_quo};

endmodule

[rtl/pvk_datapath.sv]
// ----------------------------------------------------------------------------
// pvk_datapath
// Filter state, intermediate terms and the shared multiply and divide units.
// Runs one operation per start command and reports completion.
// ----------------------------------------------------------------------------
module pvk_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pvk_pkg::t_dp_cmd   i_cmd,
    input  pvk_pkg::t_cfg      i_cfg,
    input  logic [31:0]        i_meas,
    input  logic [31:0]        i_now,
    output pvk_pkg::t_dp_stat  o_stat,
    output logic [31:0]        o_pos,
    output logic [31:0]        o_vel
);

    logic [31:0] r_pos, r_vel, r_pp, r_pv, r_vp, r_vv, r_last;
    logic [31:0] r_meas, r_now;
    logic [63:0] r_dt, r_vvdt, r_k0, r_k1;
    logic [31:0] r_dt_lo;
    logic [31:0] r_a1, r_a2, r_a3, r_a4;
    logic [31:0] r_pos_pred, r_p00, r_p01, r_p10, r_p11, r_innov, r_s;
    pvk_pkg::t_op r_op;
    logic        r_inst_done;

    logic        mul_start, mul_done, div_start, div_done, div_neg;
    logic [63:0] mul_a, mul_b, mul_prod, div_quot, dt_sum;
    logic [47:0] div_num;
    logic [31:0] div_den, ikh, abs_s, n_p00, n_s, dt_span;

    function automatic logic [63:0] ext(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    assign ikh     = pvk_pkg::Q16_ONE - r_k0[31:0];
    assign abs_s   = mag(r_s);
    assign n_p00   = r_pp + r_a1 + r_a2 + r_a4 + {1'b0, i_cfg.qpos};
    assign n_s     = n_p00 + {1'b0, i_cfg.rmeas};
    assign dt_span = r_now - r_last;
    assign dt_sum  = mul_prod + {32'd0, r_dt_lo};

    assign mul_start = i_cmd.start && !pvk_pkg::op_is_div(i_cmd.op)
                       && !pvk_pkg::op_is_inst(i_cmd.op);
    assign div_start = i_cmd.start && pvk_pkg::op_is_div(i_cmd.op);

    // Multiplier operand select
    always_comb begin
        mul_a = ext(r_vel);
        mul_b = r_dt;
        case (i_cmd.op)
            pvk_pkg::OP_DT:    begin mul_a = {32'd0, dt_span}; mul_b = pvk_pkg::DT_RECIP_LO; end
            pvk_pkg::OP_DTH:   begin mul_a = {32'd0, dt_span}; mul_b = pvk_pkg::DT_RECIP_HI; end
            pvk_pkg::OP_PVDT:  mul_a = ext(r_pv);
            pvk_pkg::OP_VPDT:  mul_a = ext(r_vp);
            pvk_pkg::OP_VVDT:  mul_a = ext(r_vv);
            pvk_pkg::OP_VVDT2: mul_a = r_vvdt;
            pvk_pkg::OP_POS:   begin mul_a = r_k0;     mul_b = ext(r_innov); end
            pvk_pkg::OP_VEL:   begin mul_a = r_k1;     mul_b = ext(r_innov); end
            pvk_pkg::OP_PP:    begin mul_a = ext(ikh); mul_b = ext(r_p00);   end
            pvk_pkg::OP_PV:    begin mul_a = ext(ikh); mul_b = ext(r_p01);   end
            pvk_pkg::OP_VP:    begin mul_a = r_k1;     mul_b = ext(r_p00);   end
            pvk_pkg::OP_VV:    begin mul_a = r_k1;     mul_b = ext(r_p01);   end
            default:           ;
        endcase
    end

    // Divider operand select
    always_comb begin
        case (i_cmd.op)
            pvk_pkg::OP_K0: begin
                div_num = {mag(r_p00), 16'd0};
                div_den = abs_s;
                div_neg = r_p00[31] ^ r_s[31];
            end
            default: begin
                div_num = {mag(r_p10), 16'd0};
                div_den = abs_s;
                div_neg = r_p10[31] ^ r_s[31];
            end
        endcase
    end

    pvk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pvk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_neg   (div_neg),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Operation tracking and single-cycle completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= pvk_pkg::OP_RESET;
            r_inst_done <= 1'b0;
        end else begin
            r_inst_done <= i_cmd.start && pvk_pkg::op_is_inst(i_cmd.op);
            if (i_cmd.start) begin
                r_op <= i_cmd.op;
            end
        end
    end

    // Filter state: written by reset command or on unit completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_vel  <= '0;
            r_pv   <= '0;
            r_vp   <= '0;
            r_last <= '0;
            r_pp   <= {1'b0, pvk_pkg::RST_PVAR};
            r_vv   <= {1'b0, pvk_pkg::RST_VVAR};
        end else if (i_cmd.start && i_cmd.op == pvk_pkg::OP_RESET) begin
            r_pos  <= '0;
            r_vel  <= '0;
            r_pv   <= '0;
            r_vp   <= '0;
            r_last <= '0;
            r_pp   <= {1'b0, i_cfg.pvar};
            r_vv   <= {1'b0, i_cfg.vvar};
        end else if (mul_done) begin
            case (r_op)
                pvk_pkg::OP_DTH: r_last <= r_now;
                pvk_pkg::OP_POS: r_pos <= r_pos_pred + mul_prod[47:16];
                pvk_pkg::OP_VEL: r_vel <= r_vel + mul_prod[47:16];
                pvk_pkg::OP_PP:  r_pp  <= mul_prod[47:16];
                pvk_pkg::OP_PV:  r_pv  <= mul_prod[47:16];
                pvk_pkg::OP_VP:  r_vp  <= r_p10 - mul_prod[47:16];
                pvk_pkg::OP_VV:  r_vv  <= r_p11 - mul_prod[47:16];
                default:         ;
            endcase
        end
    end

    // Intermediate terms
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= i_meas;
            r_now  <= i_now;
        end
        if (i_cmd.start && i_cmd.op == pvk_pkg::OP_SUMS) begin
            r_p00   <= n_p00;
            r_s     <= n_s;
            r_p01   <= r_pv + r_a3;
            r_p10   <= r_vp + r_a3;
            r_p11   <= r_vv + {1'b0, i_cfg.qvel};
            r_innov <= r_meas - r_pos_pred;
        end
        if (div_done) begin
            case (r_op)
                pvk_pkg::OP_K0: r_k0 <= div_quot;
                default:        r_k1 <= div_quot;
            endcase
        end
        if (mul_done) begin
            case (r_op)
                pvk_pkg::OP_DT:    r_dt_lo <= mul_prod[63:32];
                pvk_pkg::OP_DTH:   r_dt <= (r_last == 32'd0) ? pvk_pkg::DT_DEFAULT
                                                             : {14'd0, dt_sum[63:14]};
                pvk_pkg::OP_VDT:   r_pos_pred <= r_pos + mul_prod[47:16];
                pvk_pkg::OP_PVDT:  r_a1 <= mul_prod[47:16];
                pvk_pkg::OP_VPDT:  r_a2 <= mul_prod[47:16];
                pvk_pkg::OP_VVDT: begin
                    r_vvdt <= mul_prod;
                    r_a3   <= mul_prod[47:16];
                end
                pvk_pkg::OP_VVDT2: r_a4 <= mul_prod[63:32];
                default:           ;
            endcase
        end
    end

    assign o_stat.done   = mul_done || div_done || r_inst_done;
    assign o_stat.s_zero = (r_s == 32'd0);
    assign o_pos = r_pos;
    assign o_vel = r_vel;

endmodule

[rtl/pvk_ctrl.sv]
// ----------------------------------------------------------------------------
// pvk_ctrl
// Sequencer: accepts an item, steps the datapath through its operations and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pvk_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    input  logic               i_out_free,
    input  pvk_pkg::t_dp_stat  i_stat,
    output logic               o_in_ready,
    output pvk_pkg::t_dp_cmd   o_dp_cmd,
    output logic               o_out_load,
    output logic               o_out_fault
);

    pvk_pkg::t_state r_state, n_state;
    pvk_pkg::t_op    r_op, n_op;
    logic            r_fault, n_fault;
    logic            last_op;

    assign last_op = (r_op == pvk_pkg::OP_RESET) || (r_op == pvk_pkg::OP_VV)
                     || (r_op == pvk_pkg::OP_SUMS && i_stat.s_zero);

    // Next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_fault = r_fault;
        unique case (r_state)
            pvk_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = pvk_pkg::ST_ISSUE;
                    n_op    = i_in_cmd ? pvk_pkg::OP_RESET : pvk_pkg::OP_DT;
                    n_fault = 1'b0;
                end
            end
            pvk_pkg::ST_ISSUE: n_state = pvk_pkg::ST_WAIT;
            pvk_pkg::ST_WAIT: begin
                if (i_stat.done) begin
                    if (last_op) begin
                        n_state = pvk_pkg::ST_DONE;
                        n_fault = (r_op == pvk_pkg::OP_SUMS);
                    end else begin
                        n_state = pvk_pkg::ST_ISSUE;
                        n_op    = pvk_pkg::next_op(r_op);
                    end
                end
            end
            pvk_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = pvk_pkg::ST_IDLE;
                end
            end
            default: n_state = pvk_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_dp_cmd.load  = 1'b0;
        o_dp_cmd.start = 1'b0;
        o_dp_cmd.op    = r_op;
        o_out_load     = 1'b0;
        o_out_fault    = r_fault;
        unique case (r_state)
            pvk_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_dp_cmd.load = i_in_valid;
            end
            pvk_pkg::ST_ISSUE: o_dp_cmd.start = 1'b1;
            pvk_pkg::ST_WAIT:  ;
            pvk_pkg::ST_DONE:  o_out_load = i_out_free;
            default:           ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pvk_pkg::ST_IDLE;
            r_op    <= pvk_pkg::OP_RESET;
            r_fault <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_fault <= n_fault;
        end
    end

endmodule

[rtl/position_velocity_kalman.sv]
// A reset command shows its result after its reset step; a measurement update
// runs thirteen multiply steps, two divisions and a sum step, then loads the
// output (if S is 0, it stops after the sum step). One item at a time: the next
// item is taken in the cycle after the result moves into the output register.
// Synchronous active-low reset restores the register defaults and the filter
// state; no clearing pass.
// ----------------------------------------------------------------------------
// position_velocity_kalman
// Two-state constant-velocity Kalman filter, Q16.16, with stream ports and an
// APB register port.
// ----------------------------------------------------------------------------
module position_velocity_kalman (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // APB register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pvk_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,  // measured_position, timestamp_us
    input  logic                       s_axis_tuser,  // cmd
    // Result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,  // position_estimate, velocity_estimate
    output logic                       m_axis_tuser   // divide_fault
);

    pvk_pkg::t_cfg     r_cfg;
    pvk_pkg::t_dp_cmd  dp_cmd;
    pvk_pkg::t_dp_stat dp_stat;
    logic [31:0]       dp_pos, dp_vel;
    logic [63:0]       r_out_data;
    logic              r_out_valid, r_out_fault;
    logic              out_free, out_load, out_fault, cfg_wr;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.qpos  <= pvk_pkg::RST_QPOS;
            r_cfg.qvel  <= pvk_pkg::RST_QVEL;
            r_cfg.rmeas <= pvk_pkg::RST_RMEAS;
            r_cfg.pvar  <= pvk_pkg::RST_PVAR;
            r_cfg.vvar  <= pvk_pkg::RST_VVAR;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                pvk_pkg::REG_QPOS:  r_cfg.qpos  <= pwdata[30:0];
                pvk_pkg::REG_QVEL:  r_cfg.qvel  <= pwdata[30:0];
                pvk_pkg::REG_RMEAS: r_cfg.rmeas <= pwdata[30:0];
                pvk_pkg::REG_PVAR:  r_cfg.pvar  <= pwdata[30:0];
                pvk_pkg::REG_VVAR:  r_cfg.vvar  <= pwdata[30:0];
                default:            ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            pvk_pkg::REG_QPOS:  prdata = {1'b0, r_cfg.qpos};
            pvk_pkg::REG_QVEL:  prdata = {1'b0, r_cfg.qvel};
            pvk_pkg::REG_RMEAS: prdata = {1'b0, r_cfg.rmeas};
            pvk_pkg::REG_PVAR:  prdata = {1'b0, r_cfg.pvar};
            pvk_pkg::REG_VVAR:  prdata = {1'b0, r_cfg.vvar};
            default:            prdata = '0;
        endcase
    end

    assign out_free = !r_out_valid || m_axis_tready;

    pvk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .i_out_free  (out_free),
        .i_stat      (dp_stat),
        .o_in_ready  (s_axis_tready),
        .o_dp_cmd    (dp_cmd),
        .o_out_load  (out_load),
        .o_out_fault (out_fault)
    );

    pvk_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_cfg   (r_cfg),
        .i_meas  (s_axis_tdata[31:0]),
        .i_now   (s_axis_tdata[63:32]),
        .o_stat  (dp_stat),
        .o_pos   (dp_pos),
        .o_vel   (dp_vel)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data  <= {dp_vel, dp_pos};
            r_out_fault <= out_fault;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_fault;

endmodule

[rtl/pvk_checker.sv]
// ----------------------------------------------------------------------------
// pvk_checker
// Port-level checks of the Kalman filter block, bound to the top level.
// ----------------------------------------------------------------------------
`include "position_velocity_kalman_defines.svh"

module pvk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // One item in flight: no back-to-back acceptance
    `PVK_ASSERT_RST(a_one_in_flight, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input accepted while busy")

    // A stalled result transaction holds
    `PVK_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

    // No result is shown in the cycle after reset
    `PVK_ASSERT(a_rst_clear, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // Register port never waits
    `PVK_ASSERT(a_pready, i_clk, pready, "pready low")

endmodule

bind position_velocity_kalman pvk_checker u_pvk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/position_velocity_kalman_tb.sv]
// ----------------------------------------------------------------------------
// position_velocity_kalman_tb
// Self-checking bench for the Kalman filter block: streams update and reset
// commands through the block with random stalls and compares each estimate
// against an in-bench fixed-point model of the filter.
// ----------------------------------------------------------------------------
module position_velocity_kalman_tb;

    localparam int N_RANDOM = 1700;

    typedef struct packed {
        logic        cmd;
        logic [31:0] meas;
        logic [31:0] stamp;
    } t_meas_item;

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] vel;
        logic        fault;
    } t_estimate;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [pvk_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // measured_position, timestamp_us
    logic        s_axis_tuser = 1'b0; // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;       // position_estimate, velocity_estimate
    logic        m_axis_tuser;       // divide_fault

    position_velocity_kalman i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // filter state mirror
    logic [31:0] cfg_regs [5];
    logic [31:0] f_pos, f_vel, f_pp, f_pv, f_vp, f_vv, f_last;

    t_meas_item pending_items[$];
    t_estimate  expected_estimates[$];
    int  n_mismatch = 0;
    int  n_results = 0;
    int  n_faults = 0;
    int  n_resets = 0;

    function automatic logic [31:0] shr64(logic [63:0] v, int s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] sx(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic void restore_filter();
        f_pos = '0; f_vel = '0; f_pv = '0; f_vp = '0; f_last = '0;
        f_pp = cfg_regs[pvk_pkg::REG_PVAR];
        f_vv = cfg_regs[pvk_pkg::REG_VVAR];
    endfunction

    function automatic t_estimate kalman_update(t_meas_item it);
        t_estimate r;
        logic [63:0] dt, k0, k1;
        logic [31:0] ppred, p00, p01, p10, p11, innov, s, ikh;
        longint signed num0, num1, den;
        r.fault = 1'b0;
        if (it.cmd) begin
            restore_filter();
        end else begin
            if (f_last != 0) dt = (64'(32'(it.stamp - f_last)) * 64'd65536) / 64'd1000000;
            else dt = pvk_pkg::DT_DEFAULT;
            f_last = it.stamp;
            ppred = f_pos + shr64(sx(f_vel) * dt, 16);
            p00 = f_pp + shr64(sx(f_pv) * dt, 16) + shr64(sx(f_vp) * dt, 16)
                + shr64(sx(f_vv) * dt * dt, 32) + cfg_regs[pvk_pkg::REG_QPOS];
            p01 = f_pv + shr64(sx(f_vv) * dt, 16);
            p10 = f_vp + shr64(sx(f_vv) * dt, 16);
            p11 = f_vv + cfg_regs[pvk_pkg::REG_QVEL];
            innov = it.meas - ppred;
            s = p00 + cfg_regs[pvk_pkg::REG_RMEAS];
            if (s == 0) begin
                r.fault = 1'b1;
            end else begin
                den = $signed(sx(s));
                num0 = $signed(sx(p00)) * 65536;
                num1 = $signed(sx(p10)) * 65536;
                k0 = num0 / den;
                k1 = num1 / den;
                f_pos = ppred + shr64(k0 * sx(innov), 16);
                f_vel = f_vel + shr64(k1 * sx(innov), 16);
                ikh = 32'(64'd65536 - k0);
                f_pp = shr64(sx(ikh) * sx(p00), 16);
                f_pv = shr64(sx(ikh) * sx(p01), 16);
                f_vp = p10 - shr64(k1 * sx(p00), 16);
                f_vv = p11 - shr64(k1 * sx(p01), 16);
            end
        end
        r.pos = f_pos;
        r.vel = f_vel;
        return r;
    endfunction

    // driver: present items with random gaps, predict on acceptance
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_estimates.push_back(
                    kalman_update({s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]}));
                send_gap = $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
                if (send_gap == 0 && pending_items.size() > 0) begin
                    t_meas_item it;
                    it = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= it.cmd;
                    s_axis_tdata <= {it.stamp, it.meas};
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (send_gap > 0) send_gap = send_gap - 1;
                end
            end
        end
    end

    // monitor: random back-pressure, compare each result transaction
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_estimate want;
                n_results++;
                if (m_axis_tuser) n_faults++;
                if (expected_estimates.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected result %h", m_axis_tdata);
                end else begin
                    want = expected_estimates.pop_front();
                    if (m_axis_tdata[31:0] !== want.pos || m_axis_tdata[63:32] !== want.vel
                        || m_axis_tuser !== want.fault) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: exp pos %h vel %h fault %b, got %h %h %b",
                                     want.pos, want.vel, want.fault, m_axis_tdata[31:0],
                                     m_axis_tdata[63:32], m_axis_tuser);
                    end
                end
                recv_gap = $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) recv_gap = 0;
            end
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_estimates.size() > 0)
            @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {1'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cfg_regs[idx] = {1'b0, val};
    endtask

    function automatic void queue_item(logic cmd, logic [31:0] meas, logic [31:0] stamp);
        pending_items.push_back({cmd, meas, stamp});
        if (cmd) n_resets++;
    endfunction

    // well-formed track: reset, then steady timestamps with noisy positions
    function automatic void queue_track(int len);
        logic [31:0] t, p, v;
        t = $urandom_range(1, 100000);
        p = $urandom;
        v = $urandom_range(0, 2000) - 1000;
        queue_item(1'b1, $urandom, $urandom);
        for (int k = 0; k < len; k++) begin
            t += $urandom_range(500, 1500);
            p += v;
            if ($urandom_range(0, 19) == 0) queue_item(1'b0, $urandom, $urandom);
            else queue_item(1'b0, p + $urandom_range(0, 200) - 100, t);
        end
    endfunction

    initial begin
        cfg_regs[pvk_pkg::REG_QPOS] = pvk_pkg::RST_QPOS;
        cfg_regs[pvk_pkg::REG_QVEL] = pvk_pkg::RST_QVEL;
        cfg_regs[pvk_pkg::REG_RMEAS] = pvk_pkg::RST_RMEAS;
        cfg_regs[pvk_pkg::REG_PVAR] = pvk_pkg::RST_PVAR;
        cfg_regs[pvk_pkg::REG_VVAR] = pvk_pkg::RST_VVAR;
        restore_filter();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of fields, both commands, default time step
        queue_item(1'b0, 32'h7FFF_FFFF, 32'h0);
        queue_item(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_item(1'b0, 32'h0, 32'h0000_0001);
        queue_item(1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(1'b0, 32'd1000, 32'd1000);
        queue_item(1'b0, 32'd2000, 32'd2000);
        queue_item(1'b0, 32'd3000, 32'd2000);
        queue_item(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_item(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
        wait_drained();

        // zero innovation covariance: zero variances and noise keep S at 0
        write_reg(pvk_pkg::REG_QPOS, 31'd0);
        write_reg(pvk_pkg::REG_RMEAS, 31'd0);
        write_reg(pvk_pkg::REG_PVAR, 31'd0);
        write_reg(pvk_pkg::REG_VVAR, 31'd0);
        write_reg(pvk_pkg::REG_QVEL, 31'd0);
        queue_item(1'b1, 32'd0, 32'd0);
        queue_item(1'b0, 32'd12345, 32'd0);
        queue_item(1'b0, 32'hDEAD_BEEF, 32'd5000);
        wait_drained();

        // maximum register values
        for (int r = 0; r < 5; r++) write_reg(3'(r), 31'h7FFF_FFFF);
        queue_item(1'b1, 32'd0, 32'd0);
        for (int k = 0; k < 6; k++) queue_item(1'b0, $urandom, $urandom);
        wait_drained();

        // random phases with random settings, reset defaults last
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                write_reg(pvk_pkg::REG_QPOS, pvk_pkg::RST_QPOS);
                write_reg(pvk_pkg::REG_QVEL, pvk_pkg::RST_QVEL);
                write_reg(pvk_pkg::REG_RMEAS, pvk_pkg::RST_RMEAS);
                write_reg(pvk_pkg::REG_PVAR, pvk_pkg::RST_PVAR);
                write_reg(pvk_pkg::REG_VVAR, pvk_pkg::RST_VVAR);
            end else begin
                for (int r = 0; r < 5; r++)
                    write_reg(3'(r), ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                                 : 31'($urandom_range(0, 1 << 28)));
            end
            while (pending_items.size() < N_RANDOM / 6) begin
                if ($urandom_range(0, 4) == 0) queue_item($urandom_range(0, 1), $urandom, $urandom);
                else queue_track($urandom_range(5, 40));
            end
            wait_drained();
        end

        $display("covered %0d results, %0d reset commands, %0d divide faults",
                 n_results, n_resets, n_faults);
        $display("register settings: defaults, zeros, maxima and random values");
        if (n_mismatch == 0 && expected_estimates.size() == 0)
            $display("position_velocity_kalman verification clean");
        else
            $display("position_velocity_kalman verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 3000000);
        $display("position_velocity_kalman verification failed");
        $finish;
    end
endmodule
